// File: rtl/core/lbs_pkg.sv
// ----------------------------------------------------------------------------
// lbs_pkg
// Shared constants and types of the linear blend skinning block.
// ----------------------------------------------------------------------------
package lbs_pkg;

   localparam int MAX_BONES      = 128;
   localparam int INFLUENCES     = 4;
   localparam int ELEMS_PER_BONE = 12;
   localparam int SLOT_W         = $clog2(MAX_BONES);
   localparam int ELEM_W         = 4;
   localparam int CNT_W          = $clog2(INFLUENCES);
   localparam logic [7:0] SLOT_NONE = 8'hFF;

   localparam logic ACTION_WRITE = 1'b0;
   localparam logic ACTION_SKIN  = 1'b1;

   // One influence of one vertex as it travels down the pipeline.
   typedef struct packed {
      logic               first;
      logic               last;
      logic               contrib;
      logic               pass;
      logic [15:0]        weight;
      logic signed [31:0] raw_x;
      logic signed [31:0] raw_y;
      logic signed [31:0] raw_z;
   } pkt_type;

   typedef logic [ELEMS_PER_BONE-1:0][31:0] mat_row_type;

   function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
      logic signed [31:0] r;
      if (v > 64'sd2147483647) begin
         r = 32'sh7FFFFFFF;
      end else if (v < -64'sd2147483648) begin
         r = 32'sh80000000;
      end else begin
         r = v[31:0];
      end
      return r;
   endfunction

endpackage

// File: rtl/core/lbs_matrix_store.sv
// ----------------------------------------------------------------------------
// lbs_matrix_store
// Bone matrix memory: one element written and one whole 3x4 matrix read per
// cycle, with registered read data.
// ----------------------------------------------------------------------------
module lbs_matrix_store (
   input  logic                           clock,
   input  logic                           wr_en,
   input  logic [lbs_pkg::SLOT_W-1:0]     wr_slot,
   input  logic [lbs_pkg::ELEM_W-1:0]     wr_elem,
   input  logic [31:0]                    wr_data,
   input  logic                           rd_en,
   input  logic [lbs_pkg::SLOT_W-1:0]     rd_slot,
   output lbs_pkg::mat_row_type           rd_row
);

   lbs_pkg::mat_row_type mem [lbs_pkg::MAX_BONES];
   lbs_pkg::mat_row_type rd_row_ff;

   always_ff @(posedge clock) begin
      if (wr_en && (wr_elem < lbs_pkg::ELEM_W'(lbs_pkg::ELEMS_PER_BONE))) begin
         mem[wr_slot][wr_elem] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_row_ff <= mem[rd_slot];
      end
   end

   assign rd_row = rd_row_ff;

endmodule

// File: rtl/core/linear_blend_skinning.sv
// ----------------------------------------------------------------------------
// linear_blend_skinning
// Skins one vertex with up to four weighted bone matrices, Q16.16 fixed point.
// ----------------------------------------------------------------------------
// channel  dir  handshake               word
// req      in   req_valid / req_ready   write item or vertex
// rsp      out  rsp_valid / rsp_ready   skinned position
// csr      in   csr_valid / csr_ready   bone_count
//
// A vertex holds the request port while its influences issue, plus the entry
// that ends its list early. The single matrix memory port reads one bone
// matrix per cycle, but a stall on rsp freezes every stage at once. A write
// item is taken when the pipeline advances. The last influence passes the
// read, product, row, weight and accumulate stages before the result word.
// Reset clears the valid bits and bone_count; the matrix store is not cleared.
// ----------------------------------------------------------------------------
module linear_blend_skinning (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic               req_action,
   input  logic signed [31:0] req_pos_x,
   input  logic signed [31:0] req_pos_y,
   input  logic signed [31:0] req_pos_z,
   input  logic [31:0]        req_bone_slots,
   input  logic [63:0]        req_bone_weights,
   input  logic [6:0]         req_matrix_slot,
   input  logic [3:0]         req_matrix_element,
   input  logic signed [31:0] req_matrix_value,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic signed [31:0] rsp_skinned_x,
   output logic signed [31:0] rsp_skinned_y,
   output logic signed [31:0] rsp_skinned_z,
   output logic               rsp_passed_through,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [7:0]         csr_data
);

   logic [7:0] bone_count_ff;
   logic [lbs_pkg::CNT_W-1:0] cnt_ff, cnt_in;
   logic advance;

   logic [7:0]  cur_slot;
   logic [15:0] cur_weight;
   logic        is_none, is_bad, term, issue_last, is_skin;
   lbs_pkg::pkt_type issue_pkt;
   lbs_pkg::mat_row_type mat_row;

   logic s1_vld_ff, s2_vld_ff, s3_vld_ff, s4_vld_ff;
   lbs_pkg::pkt_type s1_pkt_ff, s2_pkt_ff, s3_pkt_ff, s4_pkt_ff;

   logic signed [63:0] prod_ff [3][3];
   logic signed [31:0] m3_ff [3];
   logic signed [31:0] row_ff [3];
   logic signed [33:0] term_ff [3];
   logic signed [35:0] acc_ff [3];
   logic signed [31:0] pos_s1 [3];

   logic               rsp_valid_ff;
   logic signed [31:0] out_ff [3];
   logic               pass_ff;

   assign advance   = !rsp_valid_ff || rsp_ready;
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         bone_count_ff <= '0;
      end else if (csr_valid) begin
         bone_count_ff <= csr_data;
      end
   end

   // Issue: walk the influence list of the word on the request port.
   always_comb begin
      cur_slot   = req_bone_slots[cnt_ff*8 +: 8];
      cur_weight = req_bone_weights[cnt_ff*16 +: 16];
      is_none    = (cur_slot == lbs_pkg::SLOT_NONE);
      is_bad     = !is_none && ((cur_slot >= bone_count_ff) ||
                   (cur_slot >= 8'(lbs_pkg::MAX_BONES)));
      term       = is_none || is_bad;
      is_skin    = (req_action == lbs_pkg::ACTION_SKIN);
      issue_last = !is_skin || term ||
                   (cnt_ff == lbs_pkg::CNT_W'(lbs_pkg::INFLUENCES - 1));
      issue_pkt.first   = (cnt_ff == '0);
      issue_pkt.last    = issue_last;
      issue_pkt.contrib = !term;
      issue_pkt.pass    = is_bad || (is_none && (cnt_ff == '0));
      issue_pkt.weight  = cur_weight;
      issue_pkt.raw_x   = req_pos_x;
      issue_pkt.raw_y   = req_pos_y;
      issue_pkt.raw_z   = req_pos_z;
      req_ready = advance && issue_last;
      cnt_in = cnt_ff;
      if (req_valid && advance) begin
         cnt_in = issue_last ? '0 : cnt_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

   lbs_matrix_store u_store (
      .clock   (clock),
      .wr_en   (advance && req_valid && !is_skin),
      .wr_slot (req_matrix_slot),
      .wr_elem (req_matrix_element),
      .wr_data (req_matrix_value),
      .rd_en   (advance && req_valid && is_skin && !term),
      .rd_slot (cur_slot[lbs_pkg::SLOT_W-1:0]),
      .rd_row  (mat_row)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
         s2_vld_ff <= 1'b0;
         s3_vld_ff <= 1'b0;
         s4_vld_ff <= 1'b0;
      end else if (advance) begin
         s1_vld_ff <= req_valid && is_skin;
         s2_vld_ff <= s1_vld_ff;
         s3_vld_ff <= s2_vld_ff;
         s4_vld_ff <= s3_vld_ff;
      end
   end

   assign pos_s1[0] = s1_pkt_ff.raw_x;
   assign pos_s1[1] = s1_pkt_ff.raw_y;
   assign pos_s1[2] = s1_pkt_ff.raw_z;

   // Stage 2: the nine element products; stage 3: row sum and offset;
   // stage 4: weight scaling.
   always_ff @(posedge clock) begin
      logic signed [65:0] rsum;
      logic signed [50:0] rval;
      logic signed [48:0] wprod;
      if (advance) begin
         s1_pkt_ff <= issue_pkt;
         s2_pkt_ff <= s1_pkt_ff;
         s3_pkt_ff <= s2_pkt_ff;
         s4_pkt_ff <= s3_pkt_ff;
         for (int r = 0; r < 3; r++) begin
            for (int k = 0; k < 3; k++) begin
               prod_ff[r][k] <= $signed(mat_row[r*4+k]) * pos_s1[k];
            end
            m3_ff[r] <= $signed(mat_row[r*4+3]);
            rsum = 66'(prod_ff[r][0]) + 66'(prod_ff[r][1]) + 66'(prod_ff[r][2]);
            rval = 51'(rsum >>> 16) + 51'(m3_ff[r]);
            row_ff[r] <= lbs_pkg::sat32(64'(rval));
            wprod = row_ff[r] * $signed({1'b0, s3_pkt_ff.weight});
            term_ff[r] <= wprod[48:15];
         end
      end
   end

   // Stage 5: accumulate influences and form the result word on the last one.
   always_ff @(posedge clock) begin
      logic signed [35:0] total;
      if (advance && s4_vld_ff) begin
         for (int r = 0; r < 3; r++) begin
            total = (s4_pkt_ff.first ? 36'sd0 : acc_ff[r]) +
                    (s4_pkt_ff.contrib ? 36'(term_ff[r]) : 36'sd0);
            acc_ff[r] <= total;
            if (s4_pkt_ff.last) begin
               out_ff[r] <= lbs_pkg::sat32(64'(total));
            end
         end
         if (s4_pkt_ff.last && s4_pkt_ff.pass) begin
            out_ff[0] <= s4_pkt_ff.raw_x;
            out_ff[1] <= s4_pkt_ff.raw_y;
            out_ff[2] <= s4_pkt_ff.raw_z;
         end
         pass_ff <= s4_pkt_ff.pass;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= s4_vld_ff && s4_pkt_ff.last;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_skinned_x      = out_ff[0];
   assign rsp_skinned_y      = out_ff[1];
   assign rsp_skinned_z      = out_ff[2];
   assign rsp_passed_through = pass_ff;

   a_ready_moves: assert property (@(posedge clock) disable iff (reset)
      req_ready |-> (!rsp_valid_ff || rsp_ready))
      else $error("request taken while the pipeline is frozen");

   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      (!advance && s4_vld_ff) |=> (s4_vld_ff && $stable(s4_pkt_ff)))
      else $error("last stage changed during a stall");

   a_rsp_from_last: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(s4_vld_ff && s4_pkt_ff.last))
      else $error("result word without a final influence");

endmodule

// File: tb/lbs_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// lbs_checker
// Watches the request, result and register channels of the skinning block,
// keeps its own copy of the bone matrices and bone_count, predicts each
// skinned position and compares every result word with the oldest prediction.
// ----------------------------------------------------------------------------
module lbs_checker
   import lbs_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   input  logic               req_ready,
   input  logic               req_action,
   input  logic signed [31:0] req_pos_x,
   input  logic signed [31:0] req_pos_y,
   input  logic signed [31:0] req_pos_z,
   input  logic [31:0]        req_bone_slots,
   input  logic [63:0]        req_bone_weights,
   input  logic [6:0]         req_matrix_slot,
   input  logic [3:0]         req_matrix_element,
   input  logic signed [31:0] req_matrix_value,
   input  logic               rsp_valid,
   input  logic               rsp_ready,
   input  logic signed [31:0] rsp_skinned_x,
   input  logic signed [31:0] rsp_skinned_y,
   input  logic signed [31:0] rsp_skinned_z,
   input  logic               rsp_passed_through,
   input  logic               csr_valid,
   input  logic               csr_ready,
   input  logic [7:0]         csr_data,
   output int                 fail_count,
   output int                 pending_count,
   output int                 result_count
);

   typedef struct {
      logic signed [31:0] x;
      logic signed [31:0] y;
      logic signed [31:0] z;
      logic               pass;
   } skin_result_type;

   logic signed [31:0] matrix_mem [MAX_BONES*ELEMS_PER_BONE];
   logic [7:0]         active_bones;
   skin_result_type    expected_skins[$];

   assign pending_count = expected_skins.size();

   function automatic logic signed [31:0] clamp32(input logic signed [67:0] v);
      if (v > 68'sd2147483647) return 32'sh7FFFFFFF;
      if (v < -68'sd2147483648) return 32'sh80000000;
      return v[31:0];
   endfunction

   function automatic skin_result_type skin_vertex(input logic signed [31:0] px,
                                                   input logic signed [31:0] py,
                                                   input logic signed [31:0] pz,
                                                   input logic [31:0] slots,
                                                   input logic [63:0] weights);
      logic signed [31:0] raw [3];
      logic signed [63:0] acc [3];
      logic signed [67:0] dot;
      logic signed [31:0] row;
      logic signed [63:0] term;
      logic [7:0]         slot;
      logic [15:0]        w;
      logic               pass;
      logic               done;
      int                 base;
      skin_result_type    res;
      raw[0] = px;
      raw[1] = py;
      raw[2] = pz;
      for (int r = 0; r < 3; r++) acc[r] = 0;
      pass = 1'b0;
      done = 1'b0;
      for (int i = 0; i < INFLUENCES && !done; i++) begin
         slot = (i < 4) ? slots[8*i +: 8] : SLOT_NONE;
         w    = (i < 4) ? weights[16*i +: 16] : 16'h0;
         if (slot == SLOT_NONE) begin
            pass = (i == 0);
            done = 1'b1;
         end else if (slot >= active_bones || slot >= MAX_BONES) begin
            pass = 1'b1;
            done = 1'b1;
         end else begin
            for (int r = 0; r < 3; r++) begin
               base = slot * ELEMS_PER_BONE + r * 4;
               dot  = 0;
               for (int k = 0; k < 3; k++) dot += matrix_mem[base + k] * raw[k];
               row  = clamp32((dot >>> 16) + matrix_mem[base + 3]);
               term = (row * $signed({1'b0, w})) >>> 15;
               acc[r] += term;
            end
         end
      end
      res.x    = pass ? raw[0] : clamp32(acc[0]);
      res.y    = pass ? raw[1] : clamp32(acc[1]);
      res.z    = pass ? raw[2] : clamp32(acc[2]);
      res.pass = pass;
      return res;
   endfunction

   always @(posedge clock) begin
      skin_result_type want;
      if (reset) begin
         active_bones = '0;
         expected_skins.delete();
         fail_count   = 0;
         result_count = 0;
      end else begin
         if (csr_valid && csr_ready) active_bones = csr_data;
         if (req_valid && req_ready) begin
            if (req_action == ACTION_SKIN) begin
               expected_skins.insert(expected_skins.size(),
                                     skin_vertex(req_pos_x, req_pos_y, req_pos_z,
                                                 req_bone_slots, req_bone_weights));
            end else if (req_matrix_element < ELEMS_PER_BONE) begin
               matrix_mem[req_matrix_slot * ELEMS_PER_BONE + req_matrix_element] =
                  req_matrix_value;
            end
         end
         if (rsp_valid && rsp_ready) begin
            result_count++;
            if (expected_skins.size() == 0) begin
               $error("result word arrived with no vertex outstanding");
               fail_count++;
            end else begin
               want = expected_skins.pop_front();
               if (rsp_skinned_x !== want.x) begin
                  $error("skinned_x: expected %0d, got %0d", want.x, rsp_skinned_x);
                  fail_count++;
               end
               if (rsp_skinned_y !== want.y) begin
                  $error("skinned_y: expected %0d, got %0d", want.y, rsp_skinned_y);
                  fail_count++;
               end
               if (rsp_skinned_z !== want.z) begin
                  $error("skinned_z: expected %0d, got %0d", want.z, rsp_skinned_z);
                  fail_count++;
               end
               if (rsp_passed_through !== want.pass) begin
                  $error("passed_through: expected %0d, got %0d", want.pass,
                         rsp_passed_through);
                  fail_count++;
               end
            end
         end
      end
   end

endmodule

// File: tb/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Stimulus for the skinning block: loads bone matrices, skins vertices with
// random influence lists over several bone_count settings, with bursty
// requests and a stalling receiver. The checker beside the block predicts
// and compares; this module reports the verdict.
// ----------------------------------------------------------------------------
module tb;
   import lbs_pkg::*;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_ready;
   logic               req_action = ACTION_WRITE;
   logic signed [31:0] req_pos_x = '0;
   logic signed [31:0] req_pos_y = '0;
   logic signed [31:0] req_pos_z = '0;
   logic [31:0]        req_bone_slots = '0;
   logic [63:0]        req_bone_weights = '0;
   logic [6:0]         req_matrix_slot = '0;
   logic [3:0]         req_matrix_element = '0;
   logic signed [31:0] req_matrix_value = '0;
   logic               rsp_valid;
   logic               rsp_ready = 1'b0;
   logic signed [31:0] rsp_skinned_x;
   logic signed [31:0] rsp_skinned_y;
   logic signed [31:0] rsp_skinned_z;
   logic               rsp_passed_through;
   logic               csr_valid = 1'b0;
   logic               csr_ready;
   logic [7:0]         csr_data = '0;

   int fail_count;
   int pending_count;
   int result_count;

   localparam int ITEM_TARGET = 850;
   localparam int DRAIN_CYCLES = 12;

   logic [11:0] written_mask [MAX_BONES];
   int          bone_limit;
   int          skins_sent;
   int          writes_sent;
   int          burst_left;
   int          ready_mode;
   int          ready_timer;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   linear_blend_skinning u_dut (.*);

   lbs_checker u_checker (.*);

   // Receiver stall pattern: switches between always ready, random and a
   // slow periodic pattern, each held for a random span.
   always @(negedge clock) begin
      if (ready_timer == 0) begin
         ready_mode  <= $urandom_range(0, 2);
         ready_timer <= $urandom_range(20, 80);
      end else begin
         ready_timer <= ready_timer - 1;
      end
      case (ready_mode)
         0: rsp_ready <= 1'b1;
         1: rsp_ready <= ($urandom_range(0, 9) < 6);
         default: rsp_ready <= (ready_timer % 7) < 2;
      endcase
   end

   initial begin
      ready_mode  = 0;
      ready_timer = 0;
   end

   initial begin
      #5ms;
      $display("TEST FAILED");
      $finish;
   end

   // Drives one word at the current falling edge and returns at the falling
   // edge after it was accepted; at the end of a burst valid drops for a
   // random gap before the task returns.
   task automatic push_word();
      req_valid = 1'b1;
      do @(posedge clock); while (!req_ready);
      @(negedge clock);
      if (req_action == ACTION_SKIN) skins_sent++;
      else writes_sent++;
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         req_valid = 1'b0;
         repeat ($urandom_range(1, 6)) @(negedge clock);
         burst_left = ($urandom_range(0, 3) == 0) ? 40 : $urandom_range(0, 10);
      end
   endtask

   task automatic write_element(input int slot, input int elem, input logic [31:0] value);
      req_action         = ACTION_WRITE;
      req_matrix_slot    = slot[6:0];
      req_matrix_element = elem[3:0];
      req_matrix_value   = value;
      req_pos_x          = $urandom;
      req_bone_slots     = $urandom;
      if (elem < ELEMS_PER_BONE) written_mask[slot][elem] = 1'b1;
      push_word();
   endtask

   task automatic skin(input logic [31:0] px, input logic [31:0] py, input logic [31:0] pz,
                       input logic [31:0] slots, input logic [63:0] weights);
      req_action         = ACTION_SKIN;
      req_pos_x          = px;
      req_pos_y          = py;
      req_pos_z          = pz;
      req_bone_slots     = slots;
      req_bone_weights   = weights;
      req_matrix_slot    = 7'($urandom);
      req_matrix_element = 4'($urandom);
      req_matrix_value   = $urandom;
      push_word();
   endtask

   // Waits until every result word has come, then lets the pipeline drain.
   task automatic wait_idle();
      req_valid = 1'b0;
      while (pending_count != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic set_bone_count(input int count);
      wait_idle();
      csr_data  = count[7:0];
      csr_valid = 1'b1;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid  = 1'b0;
      bone_limit = count;
   endtask

   function automatic logic [31:0] rand_q16();
      if ($urandom_range(0, 1)) return $urandom;
      return $urandom_range(0, 1 << 19) - (1 << 18);
   endfunction

   function automatic logic [7:0] pick_slot(input int influence);
      int usable [$];
      int roll;
      for (int s = 0; s < MAX_BONES && s < bone_limit; s++)
         if (written_mask[s] == 12'hFFF) usable.insert(usable.size(), s);
      roll = $urandom_range(0, 19);
      if (roll == 0 || (influence == 0 && roll == 1)) return SLOT_NONE;
      if (roll == 2 && bone_limit < 255) return 8'($urandom_range(bone_limit, 254));
      if (usable.size() == 0) return (bone_limit < 255) ? 8'(bone_limit) : SLOT_NONE;
      return 8'(usable[$urandom_range(0, usable.size() - 1)]);
   endfunction

   task automatic random_vertex();
      logic [31:0] slots;
      logic [63:0] weights;
      slots = $urandom;
      for (int i = 0; i < 4; i++) begin
         slots[8*i +: 8] = pick_slot(i);
         if (slots[8*i +: 8] == SLOT_NONE || slots[8*i +: 8] >= bone_limit) break;
      end
      weights = {$urandom, $urandom};
      if ($urandom_range(0, 3) == 0) weights = {4{16'h2000}};
      skin(rand_q16(), rand_q16(), rand_q16(), slots, weights);
   endtask

   task automatic load_matrix(input int slot);
      for (int e = 0; e < ELEMS_PER_BONE; e++) write_element(slot, e, rand_q16());
   endtask

   initial begin
      int counts [6];
      for (int s = 0; s < MAX_BONES; s++) written_mask[s] = '0;
      bone_limit  = 0;
      skins_sent  = 0;
      writes_sent = 0;
      burst_left  = 0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // With no bones valid every listed slot is out of range.
      skin(32'sh7FFFFFFF, 32'sh80000000, 32'h0, 32'h00000000, 64'hFFFF_FFFF_FFFF_FFFF);
      // Slot 0: unit diagonal, extreme translation column, extreme third-row terms.
      write_element(0, 0, 32'h0001_0000);
      write_element(0, 1, 32'h0);
      write_element(0, 2, 32'h0);
      write_element(0, 3, 32'h7FFFFFFF);
      write_element(0, 4, 32'h0);
      write_element(0, 5, 32'h0001_0000);
      write_element(0, 6, 32'h0);
      write_element(0, 7, 32'h80000000);
      write_element(0, 8, 32'h80000000);
      write_element(0, 9, 32'h7FFFFFFF);
      write_element(0, 10, 32'h0001_0000);
      write_element(0, 11, 32'h0);
      // Element indexes past the matrix are dropped.
      write_element(0, 12, 32'hDEAD_BEEF);
      write_element(0, 15, 32'h1234_5678);
      set_bone_count(MAX_BONES);
      // Zero weight, full weight, saturating sums, an early end, out of range, zero weights.
      skin(32'h0003_0000, 32'hFFFF_0000, 32'h7FFFFFFF, 32'hFFFF_FF00, 64'h0);
      skin(32'h0003_0000, 32'hFFFF_0000, 32'h0001_0000, 32'hFFFF_FF00, 64'h0000_0000_0000_8000);
      skin(32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h0000_0000, 64'hFFFF_FFFF_FFFF_FFFF);
      skin(32'h80000000, 32'h80000000, 32'h80000000, 32'h0000_0000, 64'hFFFF_FFFF_FFFF_FFFF);
      skin(32'h0001_0000, 32'h0002_0000, 32'h0, 32'hFF00_0000, 64'h0000_4000_4000_4000);
      skin(32'h0001_0000, 32'h0002_0000, 32'h0, 32'h00C8_0000, 64'h0000_4000_4000_4000);
      skin(32'h0001_0000, 32'h0, 32'h0, 32'h0000_0000, 64'h0000_0000_0000_0000);

      counts = '{1, 128, 0, 64, 128, 1};
      counts[3] = $urandom_range(2, 127);
      for (int p = 0; p < 6; p++) begin
         set_bone_count(counts[p]);
         load_matrix($urandom_range(0, bone_limit > 0 ? bone_limit - 1 : 127));
         while (skins_sent + writes_sent < ITEM_TARGET * (p + 1) / 6) begin
            case ($urandom_range(0, 19))
               0: load_matrix($urandom_range(0, MAX_BONES - 1));
               1, 2, 3: write_element($urandom_range(0, MAX_BONES - 1),
                                      $urandom_range(0, 15), rand_q16());
               default: random_vertex();
            endcase
            // Hold off now and then until the block has delivered everything.
            if ($urandom_range(0, 99) == 0) wait_idle();
         end
      end

      wait_idle();
      $display("Skinned %0d vertices and wrote %0d matrix words over six bone counts;",
               skins_sent, writes_sent);
      $display("%0d result words were checked.", result_count);
      if (fail_count == 0 && pending_count == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
